// ===== rtl/sorted_key_value_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key/value table
// Shared helpers that clock every property on clk and mute it during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_TOP_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SKVT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SKVT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/skvt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Shared types, codes and the string normalization function.
// ----------------------------------------------------------------------------
package skvt_pkg;

	// Default number of table entries.
	localparam int CAPACITY_DEF = 256;
	// Number of leading string bytes that are kept.
	localparam int STRING_BYTES = 8;
	// Width of a packed string word.
	localparam int STR_W = 64;
	// Width of the reported entry count.
	localparam int COUNT_OUT_W = 9;

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_DELETE  = 2'd1,
		ACT_LOOKUP  = 2'd2,
		ACT_RLOOKUP = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_DUPLICATE = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_PROBE,
		S_CHECK,
		S_DISPATCH,
		S_INS_SHIFT,
		S_INS_PUT,
		S_DEL_SHIFT,
		S_SCAN,
		S_EMIT
	} state_t;

	// One finished result handed from the engine to the output stage.
	typedef struct packed {
		status_t                status;
		logic [STR_W-1:0]       key;
		logic [STR_W-1:0]       value;
		logic [COUNT_OUT_W-1:0] count;
	} res_t;

	// Keep the leading bytes up to the first zero byte, clear the rest.
	function automatic logic [STR_W-1:0] normalize(input logic [STR_W-1:0] s);
		logic [STR_W-1:0] o;
		logic             stop;
		logic [7:0]       ch;
		o    = '0;
		stop = 1'b0;
		for (int b = 0; b < 8; b++) begin
			ch = s[56-8*b +: 8];
			if (b >= STRING_BYTES || ch == 8'h00) begin
				stop = 1'b1;
			end
			if (!stop) begin
				o[56-8*b +: 8] = ch;
			end
		end
		return o;
	endfunction

endpackage

// ===== rtl/skvt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module skvt_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/skvt_engine.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table engine
// Sequencer that searches, shifts and scans the entry memory for one request.
// ----------------------------------------------------------------------------
module skvt_engine import skvt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [1:0]       req_action,
	input  logic [STR_W-1:0] req_key,
	input  logic [STR_W-1:0] req_value,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = 2 * STR_W;

	state_t           state_q, state_d;
	action_t          act_q;
	logic [STR_W-1:0] key_q, val_q;
	logic [CW-1:0]    count_q, lo_q, hi_q, cur_q;
	logic             hit_q;
	logic [STR_W-1:0] ent_key_q, ent_val_q;
	logic             wpend_q;
	logic [AW-1:0]    waddr_q;
	logic             scan_vld_q;
	status_t          res_status_q;
	logic [STR_W-1:0] res_key_q, res_val_q;

	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [MW-1:0]    mem_wdata, mem_rdata;
	logic [STR_W-1:0] rd_key, rd_val;
	logic [CW-1:0]    mid, cur_dec;
	logic [CW+8:0]    cnt_ext;
	logic             lo_lt_hi, lo_lt_cnt, cur_lt_cnt, cur_gt_lo, full, match;

	// Entry memory: value in the upper half, key in the lower half.
	skvt_ram #(
		.WIDTH(MW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Decoded read data and search arithmetic.
	assign rd_key     = mem_rdata[STR_W-1:0];
	assign rd_val     = mem_rdata[MW-1:STR_W];
	assign mid        = lo_q + ((hi_q - lo_q) >> 1);
	assign cur_dec    = cur_q - 1'b1;
	assign lo_lt_hi   = lo_q < hi_q;
	assign lo_lt_cnt  = lo_q < count_q;
	assign cur_lt_cnt = cur_q < count_q;
	assign cur_gt_lo  = cur_q > lo_q;
	assign full       = count_q >= CW'(CAPACITY);
	assign match      = scan_vld_q && (rd_val == val_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_SEARCH;
			end
			S_SEARCH: begin
				if (lo_lt_hi) state_d = S_PROBE;
				else if (lo_lt_cnt) state_d = S_CHECK;
				else state_d = S_DISPATCH;
			end
			S_PROBE: state_d = S_SEARCH;
			S_CHECK: state_d = S_DISPATCH;
			S_DISPATCH: begin
				case (act_q)
					ACT_INSERT: state_d = (hit_q || full) ? S_EMIT : S_INS_SHIFT;
					ACT_DELETE: state_d = hit_q ? S_DEL_SHIFT : S_EMIT;
					ACT_LOOKUP: state_d = S_EMIT;
					default: state_d = S_SCAN;
				endcase
			end
			S_INS_SHIFT: begin
				if (!cur_gt_lo) state_d = S_INS_PUT;
			end
			S_INS_PUT: state_d = S_EMIT;
			S_DEL_SHIFT: begin
				if (!cur_lt_cnt) state_d = S_EMIT;
			end
			S_SCAN: begin
				if (match || (!cur_lt_cnt && !scan_vld_q)) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory port control and handshake outputs.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			S_IDLE: req_ready = 1'b1;
			S_SEARCH: begin
				if (lo_lt_hi) begin
					mem_re    = 1'b1;
					mem_raddr = mid[AW-1:0];
				end else if (lo_lt_cnt) begin
					mem_re    = 1'b1;
					mem_raddr = lo_q[AW-1:0];
				end
			end
			S_INS_SHIFT: begin
				if (cur_gt_lo) begin
					mem_re    = 1'b1;
					mem_raddr = cur_dec[AW-1:0];
				end
			end
			S_DEL_SHIFT: begin
				if (cur_lt_cnt) begin
					mem_re    = 1'b1;
					mem_raddr = cur_q[AW-1:0];
				end
			end
			S_SCAN: begin
				if (!match && cur_lt_cnt) begin
					mem_re    = 1'b1;
					mem_raddr = cur_q[AW-1:0];
				end
			end
			S_EMIT: res_valid = 1'b1;
			default: ;
		endcase
		// The new entry goes in after the shift has drained; otherwise the
		// word read last cycle is written one place over.
		if (state_q == S_INS_PUT) begin
			mem_we    = 1'b1;
			mem_waddr = lo_q[AW-1:0];
			mem_wdata = {val_q, key_q};
		end else begin
			mem_we    = wpend_q;
			mem_waddr = waddr_q;
			mem_wdata = mem_rdata;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			wpend_q    <= 1'b0;
			scan_vld_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			wpend_q    <= ((state_q == S_INS_SHIFT) && cur_gt_lo) ||
			              ((state_q == S_DEL_SHIFT) && cur_lt_cnt);
			scan_vld_q <= (state_q == S_SCAN) && !match && cur_lt_cnt;
			if (state_q == S_INS_PUT) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == S_DEL_SHIFT && !cur_lt_cnt) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Request, search and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					act_q <= action_t'(req_action);
					key_q <= req_key;
					val_q <= req_value;
					lo_q  <= '0;
					hi_q  <= count_q;
					hit_q <= 1'b0;
				end
			end
			S_PROBE: begin
				if (rd_key < key_q) lo_q <= mid + 1'b1;
				else hi_q <= mid;
			end
			S_CHECK: begin
				hit_q     <= (rd_key == key_q);
				ent_key_q <= rd_key;
				ent_val_q <= rd_val;
			end
			S_DISPATCH: begin
				res_status_q <= STAT_NOT_FOUND;
				res_key_q    <= '0;
				res_val_q    <= '0;
				cur_q        <= '0;
				case (act_q)
					ACT_INSERT: begin
						cur_q <= count_q;
						if (hit_q) begin
							res_status_q <= STAT_DUPLICATE;
							res_key_q    <= ent_key_q;
							res_val_q    <= ent_val_q;
						end else if (full) begin
							res_status_q <= STAT_FULL;
						end else begin
							res_status_q <= STAT_DONE;
							res_key_q    <= key_q;
							res_val_q    <= val_q;
						end
					end
					ACT_DELETE, ACT_LOOKUP: begin
						cur_q <= lo_q + 1'b1;
						if (hit_q) begin
							res_status_q <= STAT_DONE;
							res_key_q    <= ent_key_q;
							res_val_q    <= ent_val_q;
						end
					end
					default: ;
				endcase
			end
			S_INS_SHIFT: begin
				if (cur_gt_lo) begin
					cur_q   <= cur_dec;
					waddr_q <= cur_q[AW-1:0];
				end
			end
			S_DEL_SHIFT: begin
				if (cur_lt_cnt) begin
					cur_q   <= cur_q + 1'b1;
					waddr_q <= cur_dec[AW-1:0];
				end
			end
			S_SCAN: begin
				if (match) begin
					res_status_q <= STAT_DONE;
					res_key_q    <= rd_key;
					res_val_q    <= rd_val;
				end else if (cur_lt_cnt) begin
					cur_q <= cur_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Result word; the count is reported modulo the output width.
	assign cnt_ext      = {{COUNT_OUT_W{1'b0}}, count_q};
	assign res.status   = res_status_q;
	assign res.key      = res_key_q;
	assign res.value    = res_val_q;
	assign res.count    = cnt_ext[COUNT_OUT_W-1:0];

endmodule

// ===== rtl/sorted_key_value_table_top.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table
// A table of key/value string pairs kept in ascending key order in one RAM.
// ----------------------------------------------------------------------------
// Requests arrive as words on the s_axis channel: tuser carries the action
// (insert, delete, lookup by key, lookup by value), tdata the key and value.
// Keys and values are trimmed at their first zero byte on entry. Every
// request returns exactly one word on m_axis: tuser carries the status,
// tdata the entry concerned and the entry count after the request.
// One request is worked on at a time. A binary search spends a SEARCH and
// a PROBE state on each probe, then a CHECK of the entry it lands on, if
// any. Insert and delete then move one entry per cycle through the single
// RAM write port. A lookup by value reads one entry per cycle from the front.
// A finished result sits in the output register; the next request is taken
// while it waits, and its own result holds until m_axis_tready frees the slot.
// Reset empties the table at once; no clearing pass is needed.
module sorted_key_value_table_top import skvt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // key[63:0], value[127:64]
	input  logic [1:0]   s_axis_tuser,  // action[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata,  // key_out[63:0], value_out[127:64],
	                                    // count_after[136:128], zero[143:137]
	output logic [1:0]   m_axis_tuser   // status[1:0]
);

	logic             res_valid, res_ready;
	res_t             res;
	res_t             out_q;
	logic             out_valid_q;
	logic [STR_W-1:0] key_norm, val_norm;

	// Trim incoming strings so equal C strings give equal words.
	assign key_norm = normalize(s_axis_tdata[STR_W-1:0]);
	assign val_norm = normalize(s_axis_tdata[2*STR_W-1:STR_W]);

	skvt_engine #(
		.CAPACITY(CAPACITY)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req_action(s_axis_tuser),
		.req_key   (key_norm),
		.req_value (val_norm),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: loads whenever the slot is empty or being drained.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {7'd0, out_q.count, out_q.value, out_q.key};

endmodule

// ===== rtl/skvt_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value table port checker
// Watches the top-level ports and flags results that break the contract.
// ----------------------------------------------------------------------------
`include "sorted_key_value_table_top_defines.svh"

module skvt_checker import skvt_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [143:0] m_axis_tdata,  // key_out, value_out, count_after, zero
	input logic [1:0]   m_axis_tuser   // status[1:0]
);

	logic         out_stall, in_take, miss, full_rep, entry_zero, count_cap;
	logic [145:0] out_word;

	// Conditions watched by the properties below.
	assign out_stall  = m_axis_tvalid && !m_axis_tready;
	assign out_word   = {m_axis_tuser, m_axis_tdata};
	assign in_take    = s_axis_tvalid && s_axis_tready;
	assign miss       = m_axis_tvalid && (m_axis_tuser == STAT_NOT_FOUND);
	assign full_rep   = m_axis_tvalid && (m_axis_tuser == STAT_FULL);
	assign entry_zero = (m_axis_tdata[127:0] == 128'd0);
	assign count_cap  = (m_axis_tdata[136:128] == 9'(CAPACITY));

	// A stalled result word holds.
	`SKVT_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "result not held")

	// Requests are worked one at a time: an accepted word drops ready.
	`SKVT_ASSERT_NXT(a_one_at_a_time, in_take, !s_axis_tready, "request taken while busy")

	// A miss reports an empty entry.
	`SKVT_ASSERT_IMP(a_miss_zero, miss, entry_zero, "not-found result carries entry data")

	// A full table report comes only with the count at capacity.
	`SKVT_ASSERT_IMP(a_full_count, full_rep, count_cap && entry_zero, "bad table-full result")

endmodule

bind sorted_key_value_table_top skvt_checker #(
	.CAPACITY(CAPACITY)
) u_skvt_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the sorted key/value table
// Drives requests on s_axis, predicts each result from a table of its own,
// and checks every word that comes back on m_axis. A short table of directed
// requests covers the empty table, extreme keys and values, string trimming,
// duplicates and first-match order. Random requests then fill the table past
// capacity, drain it again, and finish with a mixed workload.
// ----------------------------------------------------------------------------
module tb_top;
	import skvt_pkg::*;

	localparam int  CYCLE_LIMIT  = 4_000_000;
	localparam int  LONG_HOLD    = 2000;
	localparam int  HOLD_AT      = 300;
	localparam int  QUIET_TAIL   = 250;
	localparam int  SETTLE       = 400;
	localparam int  N_DIRECTED   = 25;

	typedef enum int {
		PH_FILL,
		PH_DRAIN,
		PH_MIXED
	} phase_t;

	// One directed request; want is used only where typed is set.
	typedef struct {
		action_t          act;
		logic [STR_W-1:0] key;
		logic [STR_W-1:0] value;
		bit               typed;
		res_t             want;
	} req_row_t;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata  = '0;   // key[63:0], value[127:64]
	logic [1:0]   s_axis_tuser  = '0;   // action[1:0]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [143:0] m_axis_tdata;         // key_out[63:0], value_out[127:64],
	                                    // count_after[136:128], zero[143:137]
	logic [1:0]   m_axis_tuser;         // status[1:0]

	// Shadow copy of the table, kept in ascending key order.
	logic [STR_W-1:0] tbl_keys [CAPACITY_DEF];
	logic [STR_W-1:0] tbl_vals [CAPACITY_DEF];
	int               tbl_count = 0;

	res_t pending_results [$];
	int   err_count    = 0;
	int   results_seen = 0;
	int   cycle_count  = 0;
	bit   quiet        = 1'b0;
	bit   long_hold_done = 1'b0;

	// Directed requests. Rows with typed results are the ones that can be read
	// off directly; the rest go through the predictor.
	req_row_t dir_rows [N_DIRECTED] = '{
		// Empty table: every search misses.
		'{ACT_LOOKUP,  64'h4142_4300_0000_0000, 64'h0, 1'b1,
			'{STAT_NOT_FOUND, 64'h0, 64'h0, 9'd0}},
		'{ACT_DELETE,  64'h4142_4300_0000_0000, 64'h0, 1'b1,
			'{STAT_NOT_FOUND, 64'h0, 64'h0, 9'd0}},
		'{ACT_RLOOKUP, 64'h0, 64'h5800_0000_0000_0000, 1'b1,
			'{STAT_NOT_FOUND, 64'h0, 64'h0, 9'd0}},
		// Largest key with an empty value, then the empty key with the largest value.
		'{ACT_INSERT,  64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1,
			'{STAT_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 9'd1}},
		'{ACT_INSERT,  64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			'{STAT_DONE, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 9'd2}},
		// Bytes after the terminator must be dropped from key and value.
		'{ACT_INSERT,  64'h4D00_1234_5678_9ABC, 64'h7631_0055_AA00_0000, 1'b0, '0},
		'{ACT_INSERT,  64'h4D00_0000_0000_0000, 64'h0102_0304_0506_0708, 1'b0, '0},
		'{ACT_LOOKUP,  64'h4D00_FFFF_FFFF_FFFF, 64'h0, 1'b0, '0},
		'{ACT_LOOKUP,  64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1,
			'{STAT_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 9'd3}},
		'{ACT_LOOKUP,  64'h0, 64'h0, 1'b1,
			'{STAT_DONE, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 9'd3}},
		'{ACT_RLOOKUP, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			'{STAT_DONE, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 9'd3}},
		'{ACT_RLOOKUP, 64'h0, 64'h0, 1'b1,
			'{STAT_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 9'd3}},
		// A second empty value under a smaller key wins the value search.
		'{ACT_INSERT,  64'h4200_0000_0000_0000, 64'h00FF_FFFF_0000_0000, 1'b0, '0},
		'{ACT_RLOOKUP, 64'h0, 64'h0000_1111_0000_0000, 1'b0, '0},
		'{ACT_INSERT,  64'h0102_0304_0506_0708, 64'h0102_0304_0506_0708, 1'b0, '0},
		'{ACT_RLOOKUP, 64'h0, 64'h0102_0304_0506_0708, 1'b0, '0},
		'{ACT_RLOOKUP, 64'h0, 64'h7700_0000_0000_0000, 1'b0, '0},
		// Delete found, then the same key again, then a lookup of it.
		'{ACT_DELETE,  64'h4D00_AAAA_0000_0000, 64'h0, 1'b0, '0},
		'{ACT_DELETE,  64'h4D00_0000_0000_0000, 64'h0, 1'b0, '0},
		'{ACT_LOOKUP,  64'h4D00_0000_0000_0000, 64'h0, 1'b0, '0},
		'{ACT_DELETE,  64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, '0},
		'{ACT_DELETE,  64'h0, 64'h0, 1'b0, '0},
		'{ACT_DELETE,  64'h4200_0000_0000_0000, 64'h0, 1'b0, '0},
		'{ACT_DELETE,  64'h0102_0304_0506_0708, 64'h0, 1'b0, '0},
		'{ACT_LOOKUP,  64'h0, 64'h0, 1'b1,
			'{STAT_NOT_FOUND, 64'h0, 64'h0, 9'd0}}
	};

	sorted_key_value_table_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Cycle count and run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Keep the bytes up to the first zero byte and clear everything after it.
	function automatic logic [STR_W-1:0] trim_string(input logic [STR_W-1:0] s);
		logic [STR_W-1:0] o;
		bit               ended;
		o     = '0;
		ended = 1'b0;
		for (int b = 0; b < 8; b++) begin
			if (b >= STRING_BYTES || s[56-8*b +: 8] == 8'h00) begin
				ended = 1'b1;
			end
			if (!ended) begin
				o[56-8*b +: 8] = s[56-8*b +: 8];
			end
		end
		return o;
	endfunction

	// First position whose key is not below k.
	function automatic int key_position(input logic [STR_W-1:0] k);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = tbl_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (tbl_keys[mid] < k) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

	// Apply one request to the shadow table and return the result it gives.
	function automatic res_t apply_request(input action_t act, input logic [STR_W-1:0] k_raw,
	                                       input logic [STR_W-1:0] v_raw);
		logic [STR_W-1:0] k;
		logic [STR_W-1:0] v;
		res_t             r;
		int               pos;
		bit               hit;
		k   = trim_string(k_raw);
		v   = trim_string(v_raw);
		r   = '{STAT_NOT_FOUND, '0, '0, '0};
		pos = key_position(k);
		hit = (pos < tbl_count) && (tbl_keys[pos] == k);
		case (act)
			ACT_INSERT: begin
				if (hit) begin
					r.status = STAT_DUPLICATE;
					r.key    = tbl_keys[pos];
					r.value  = tbl_vals[pos];
				end else if (tbl_count >= CAPACITY_DEF) begin
					r.status = STAT_FULL;
				end else begin
					for (int i = tbl_count; i > pos; i--) begin
						tbl_keys[i] = tbl_keys[i-1];
						tbl_vals[i] = tbl_vals[i-1];
					end
					tbl_keys[pos] = k;
					tbl_vals[pos] = v;
					tbl_count++;
					r.status = STAT_DONE;
					r.key    = k;
					r.value  = v;
				end
			end
			ACT_DELETE: begin
				if (hit) begin
					r.status = STAT_DONE;
					r.key    = tbl_keys[pos];
					r.value  = tbl_vals[pos];
					for (int i = pos; i + 1 < tbl_count; i++) begin
						tbl_keys[i] = tbl_keys[i+1];
						tbl_vals[i] = tbl_vals[i+1];
					end
					tbl_count--;
				end
			end
			ACT_LOOKUP: begin
				if (hit) begin
					r.status = STAT_DONE;
					r.key    = tbl_keys[pos];
					r.value  = tbl_vals[pos];
				end
			end
			default: begin
				// Scan in key order; the first matching value wins.
				for (int i = 0; i < tbl_count; i++) begin
					if (r.status != STAT_DONE && tbl_vals[i] == v) begin
						r.status = STAT_DONE;
						r.key    = tbl_keys[i];
						r.value  = tbl_vals[i];
					end
				end
			end
		endcase
		r.count = tbl_count[COUNT_OUT_W-1:0];
		return r;
	endfunction

	// Sometimes fill the bytes after the terminator with junk.
	function automatic logic [STR_W-1:0] add_junk(input logic [STR_W-1:0] s);
		logic [STR_W-1:0] o;
		bit               past_end;
		o        = s;
		past_end = 1'b0;
		if ($urandom_range(0, 1) == 1) begin
			for (int b = 0; b < 8; b++) begin
				if (past_end) begin
					o[56-8*b +: 8] = 8'($urandom);
				end
				if (s[56-8*b +: 8] == 8'h00) begin
					past_end = 1'b1;
				end
			end
		end
		return o;
	endfunction

	// A fresh string of random length, now and then a fully random word.
	function automatic logic [STR_W-1:0] random_string();
		logic [STR_W-1:0] s;
		int               len;
		s = '0;
		if ($urandom_range(0, 15) == 0) begin
			s = {$urandom, $urandom};
		end else begin
			len = $urandom_range(0, 8);
			for (int b = 0; b < len; b++) begin
				s[56-8*b +: 8] = 8'($urandom_range(1, 255));
			end
		end
		return add_junk(s);
	endfunction

	// Choose one random request, weighted by the phase of the run.
	task automatic pick_request(input phase_t ph, output action_t act,
	                            output logic [STR_W-1:0] k, output logic [STR_W-1:0] v);
		int roll;
		int hit_pct;
		roll = $urandom_range(0, 99);
		case (ph)
			PH_FILL: begin
				act     = roll < 85 ? ACT_INSERT : roll < 90 ? ACT_DELETE :
				          roll < 95 ? ACT_LOOKUP : ACT_RLOOKUP;
				hit_pct = 10;
			end
			PH_DRAIN: begin
				act     = roll < 10 ? ACT_INSERT : roll < 80 ? ACT_DELETE :
				          roll < 90 ? ACT_LOOKUP : ACT_RLOOKUP;
				hit_pct = 90;
			end
			default: begin
				act     = roll < 30 ? ACT_INSERT : roll < 55 ? ACT_DELETE :
				          roll < 80 ? ACT_LOOKUP : ACT_RLOOKUP;
				hit_pct = 50;
			end
		endcase
		if (tbl_count > 0 && $urandom_range(0, 99) < hit_pct) begin
			k = add_junk(tbl_keys[$urandom_range(0, tbl_count - 1)]);
		end else begin
			k = random_string();
		end
		// Values come from a tiny set often enough that several entries share one.
		if (act == ACT_RLOOKUP && tbl_count > 0 && $urandom_range(0, 99) < 60) begin
			v = add_junk(tbl_vals[$urandom_range(0, tbl_count - 1)]);
		end else if ($urandom_range(0, 3) == 0) begin
			v = add_junk(64'(8'h40 + $urandom_range(1, 3)) << 56);
		end else begin
			v = random_string();
		end
	endtask

	// Offer one request word, wait until it is taken, and queue its result.
	task automatic offer_request(input action_t act, input logic [STR_W-1:0] k,
	                             input logic [STR_W-1:0] v, input bit typed, input res_t want);
		res_t predicted;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {v, k};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		predicted = apply_request(act, k, v);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Random gap on the request side, except in calm stretches and at the end.
	task automatic sender_gap(input int idx);
		if (!quiet && (idx / 64) % 4 != 0 && $urandom_range(0, 2) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// Compare one result word with the oldest expectation.
	function automatic void check_result();
		res_t got;
		res_t want;
		got.status = status_t'(m_axis_tuser);
		got.key    = m_axis_tdata[63:0];
		got.value  = m_axis_tdata[127:64];
		got.count  = m_axis_tdata[136:128];
		results_seen++;
		if (pending_results.size() == 0) begin
			$error("result word with no request waiting: status %0d key %h",
			       got.status, got.key);
			err_count++;
			return;
		end
		want = pending_results.pop_front();
		if (got.status != want.status) begin
			$error("status: expected %s, got %s", want.status.name(), got.status.name());
			err_count++;
		end
		if (got.key != want.key) begin
			$error("key_out: expected %h, got %h", want.key, got.key);
			err_count++;
		end
		if (got.value != want.value) begin
			$error("value_out: expected %h, got %h", want.value, got.value);
			err_count++;
		end
		if (got.count != want.count) begin
			$error("count_after: expected %0d, got %0d", want.count, got.count);
			err_count++;
		end
	endfunction

	// Result side: check every word taken, stall in random bursts, and hold
	// off once for a long stretch so that the block backs up into its input.
	initial begin : result_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				check_result();
			end
			if (results_seen == HOLD_AT && !long_hold_done) begin
				long_hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && (cycle_count / 500) % 4 != 0
			             && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Request side: reset, directed table, then the random phases.
	initial begin : request_side
		phase_t           ph;
		int               phase_len [3];
		int               total;
		int               idx;
		action_t          act;
		logic [STR_W-1:0] k;
		logic [STR_W-1:0] v;
		phase_len[PH_FILL]  = 450;
		phase_len[PH_DRAIN] = 450;
		phase_len[PH_MIXED] = 1100;
		total = phase_len[PH_FILL] + phase_len[PH_DRAIN] + phase_len[PH_MIXED];
		idx   = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIRECTED; r++) begin
			offer_request(dir_rows[r].act, dir_rows[r].key, dir_rows[r].value,
			              dir_rows[r].typed, dir_rows[r].want);
			sender_gap(r);
		end

		ph = PH_FILL;
		for (int p = 0; p < 3; p++) begin
			ph = phase_t'(p);
			for (int n = 0; n < phase_len[p]; n++) begin
				quiet = (idx >= total - QUIET_TAIL);
				pick_request(ph, act, k, v);
				offer_request(act, k, v, 1'b0, '0);
				sender_gap(idx);
				idx++;
			end
		end
		s_axis_tvalid <= 1'b0;

		// Drain the results still owed, then let the block settle.
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
